[rtl/olad_pkg.sv]
// shared types and constants for the ordered list append/delete unit
package olad_pkg;

   // fixed field widths of the request and response beats
   localparam int CMD_WIDTH   = 2;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_WIDTH   = 5;
   localparam int COUNT_WIDTH = 5;

   // command codes
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_APPEND     = 2'd0,
      CMD_DEL_FIRST  = 2'd1,
      CMD_DEL_LAST   = 2'd2,
      CMD_DEL_AT_POS = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // per-cycle operation broadcast to every cell
   typedef struct packed {
      logic append;
      logic shift;
   } cell_op_type;

endpackage

[rtl/olad_ifs.sv]
// request and response channel interfaces of the ordered list unit

// request channel: command, value and position
interface olad_req_if;
   logic                                       valid;
   logic                                       ready;
   olad_pkg::cmd_type                          cmd;
   logic signed [olad_pkg::VALUE_WIDTH-1:0]    value;
   logic [olad_pkg::POS_WIDTH-1:0]             position;

   modport source (output valid, cmd, value, position, input ready);
   modport sink   (input valid, cmd, value, position, output ready);
endinterface

// response channel: status, entry count and removed value
interface olad_rsp_if;
   logic                                       valid;
   logic                                       ready;
   olad_pkg::status_type                       status;
   logic [olad_pkg::COUNT_WIDTH-1:0]           entry_count;
   logic signed [olad_pkg::VALUE_WIDTH-1:0]    removed_value;

   modport source (output valid, status, entry_count, removed_value, input ready);
   modport sink   (input valid, status, entry_count, removed_value, output ready);
endinterface

[rtl/olad_cell.sv]
// one list cell: holds one entry, loads a new value or its right neighbor
module olad_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CNT_WIDTH  = 5,
   parameter int POS        = 0
) (
   input  logic                         clock,
   input  olad_pkg::cell_op_type        op,
   input  logic [CNT_WIDTH-1:0]         count,
   input  logic [CNT_WIDTH-1:0]         del_idx,
   input  logic signed [DATA_WIDTH-1:0] new_data,
   input  logic signed [DATA_WIDTH-1:0] next_data,
   output logic signed [DATA_WIDTH-1:0] data
);

   localparam logic [CNT_WIDTH-1:0] MY_POS  = CNT_WIDTH'(POS);
   localparam logic [CNT_WIDTH-1:0] NXT_POS = CNT_WIDTH'(POS + 1);

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;
   logic                         load_new;
   logic                         load_next;

   // this cell is the tail slot on append, or sits in the gap on delete
   assign load_new  = op.append && (count == MY_POS);
   assign load_next = op.shift && (MY_POS >= del_idx) && (NXT_POS < count);

   always_comb begin
      data_in = data_ff;
      if (load_new) begin
         data_in = new_data;
      end else if (load_next) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/ordered_list_append_delete_unit.sv]
// top level of the ordered list unit: command decode, cell chain, response register
//
// Keeps an ordered list of up to DEPTH signed words in a chain of cells.
// Request beats on req carry cmd, value and position: append at tail,
// delete first, delete last or delete at a 1-based position. Every request
// beat yields exactly one response beat on rsp with status, the entry count
// after the command and the removed value (zero when nothing was removed).
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one command per cycle while the receiver keeps up; every
// cell updates in parallel from its right neighbor, so a delete closes the gap in the same update as the count.
// The response register parts the two sides: req.ready is high while the
// response register is empty or being taken this cycle. When the receiver
// stalls, the pending response holds and no further request is accepted.
// Reset (synchronous, active high) empties the list and drops any pending
// response; entry storage is not cleared, only entries below the count
// are ever read.
module ordered_list_append_delete_unit #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   olad_req_if.sink  req,
   olad_rsp_if.source rsp
);

   import olad_pkg::*;

   localparam int CW        = $clog2(DEPTH + 1);
   localparam int IW        = $clog2(DEPTH);
   localparam int CMP_WIDTH = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   logic                          fire;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic [CW-1:0]                 del_idx;
   logic [CMP_WIDTH-1:0]          pos_ext;
   logic [CMP_WIDTH-1:0]          count_ext;
   cell_op_type                   op;
   status_type                    status_in;
   logic                          removing;
   logic signed [DATA_WIDTH-1:0]  new_data;
   logic signed [DATA_WIDTH-1:0]  entry_q [DEPTH];
   logic signed [VALUE_WIDTH-1:0] removed_in;

   logic                          rsp_valid_ff;
   status_type                    status_ff;
   logic [COUNT_WIDTH-1:0]        entry_count_ff;
   logic signed [VALUE_WIDTH-1:0] removed_ff;

   // handshake
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   assign pos_ext   = CMP_WIDTH'(req.position);
   assign count_ext = CMP_WIDTH'(count_ff);
   assign new_data  = DATA_WIDTH'(req.value);

   // command decode
   always_comb begin
      status_in = ST_OK;
      removing  = 1'b0;
      op        = '0;
      del_idx   = '0;
      count_in  = count_ff;
      case (req.cmd)
         CMD_APPEND: begin
            if (count_ff == CW'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               op.append = fire;
               count_in  = count_ff + 1'b1;
            end
         end
         CMD_DEL_FIRST: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               removing = 1'b1;
               del_idx  = '0;
            end
         end
         CMD_DEL_LAST: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               removing = 1'b1;
               del_idx  = count_ff - 1'b1;
            end
         end
         CMD_DEL_AT_POS: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (pos_ext == '0 || pos_ext > count_ext) begin
               status_in = ST_BADPOS;
            end else begin
               removing = 1'b1;
               del_idx  = CW'(pos_ext - 1'b1);
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      if (removing) begin
         op.shift = fire;
         count_in = count_ff - 1'b1;
      end
   end

   // removed entry, reported in the 32-bit field
   assign removed_in = removing ? VALUE_WIDTH'(entry_q[del_idx[IW-1:0]]) : '0;

   // chain of cells, each fed by its right neighbor
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] next_data;
      if (i < DEPTH - 1) begin : g_mid
         assign next_data = entry_q[i+1];
      end else begin : g_last
         assign next_data = '0;
      end
      olad_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_WIDTH  (CW),
         .POS        (i)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .count     (count_ff),
         .del_idx   (del_idx),
         .new_data  (new_data),
         .next_data (next_data),
         .data      (entry_q[i])
      );
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff      <= status_in;
         entry_count_ff <= COUNT_WIDTH'(count_in);
         removed_ff     <= removed_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.entry_count   = entry_count_ff;
   assign rsp.removed_value = removed_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("accepted beat without response");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_OK) |-> (removed_ff == '0))
      else $error("removed value on error status");

   a_delete_count: assert property (@(posedge clock) disable iff (reset)
      (fire && removing) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("delete did not lower count");

endmodule

[bench/testbench.sv]
// self-checking testbench for the ordered list append/delete unit
module testbench;
   import olad_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int HOLD_CYCLES = 60;
   localparam int RANDOM_ITEMS = 600;

   // one request beat and one response beat, as the bench sees them
   typedef struct {
      cmd_type                       cmd;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [POS_WIDTH-1:0]          position;
   } list_cmd_type;

   typedef struct {
      status_type                    status;
      logic [COUNT_WIDTH-1:0]        entry_count;
      logic signed [VALUE_WIDTH-1:0] removed_value;
   } list_reply_type;

   // directed stimulus row; reply is used only when typed is set
   typedef struct {
      list_cmd_type   beat;
      bit             typed;
      list_reply_type reply;
   } directed_row_type;

   logic clock;
   logic reset;

   olad_req_if req_ch ();
   olad_rsp_if rsp_ch ();

   ordered_list_append_delete_unit #(
      .DEPTH      (LIST_DEPTH),
      .DATA_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // shadow copy of the list contents
   logic signed [VALUE_WIDTH-1:0] list_words [LIST_DEPTH];
   int unsigned                   list_len;

   list_reply_type   expected_replies [$];
   directed_row_type directed_rows [$];
   int unsigned      fail_count;
   int unsigned      sender_idle_pct;
   int unsigned      receiver_idle_pct;
   bit               long_hold_wanted;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // apply one command to the shadow list and return the reply it yields
   function automatic list_reply_type apply_command(input list_cmd_type c);
      list_reply_type r;
      int unsigned idx;
      r.status        = ST_OK;
      r.removed_value = '0;
      idx             = 0;
      if (c.cmd == CMD_APPEND) begin
         if (list_len >= LIST_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            list_words[list_len] = c.value;
            list_len++;
         end
      end else if (list_len == 0) begin
         r.status = ST_EMPTY;
      end else begin
         case (c.cmd)
            CMD_DEL_FIRST: begin
               idx = 0;
            end
            CMD_DEL_LAST: begin
               idx = list_len - 1;
            end
            default: begin
               if (c.position == 0 || c.position > list_len)
                  r.status = ST_BADPOS;
               else
                  idx = c.position - 1;
            end
         endcase
         // later entries move up to close the gap
         if (r.status == ST_OK) begin
            r.removed_value = list_words[idx];
            for (int i = idx; i + 1 < list_len; i++)
               list_words[i] = list_words[i + 1];
            list_len--;
         end
      end
      r.entry_count = list_len[COUNT_WIDTH-1:0];
      return r;
   endfunction

   function automatic void add_row(input cmd_type cmd, input logic signed [31:0] value,
                                   input logic [4:0] position, input bit typed,
                                   input status_type status, input logic [4:0] entry_count,
                                   input logic signed [31:0] removed_value);
      directed_row_type row;
      row.beat.cmd            = cmd;
      row.beat.value          = value;
      row.beat.position       = position;
      row.typed               = typed;
      row.reply.status        = status;
      row.reply.entry_count   = entry_count;
      row.reply.removed_value = removed_value;
      directed_rows.push_back(row);
   endfunction

   // random command; append_pct steers the list toward full or empty
   function automatic list_cmd_type random_command(input int unsigned append_pct);
      list_cmd_type c;
      c.value    = $urandom;
      c.position = POS_WIDTH'($urandom_range(31));
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(3))
            0: c.value = 32'sh7fff_ffff;
            1: c.value = 32'sh8000_0000;
            2: c.value = -32'sd1;
            default: c.value = '0;
         endcase
      end
      if ($urandom_range(99) < append_pct) begin
         c.cmd = CMD_APPEND;
      end else begin
         case ($urandom_range(2))
            0: c.cmd = CMD_DEL_FIRST;
            1: c.cmd = CMD_DEL_LAST;
            default: c.cmd = CMD_DEL_AT_POS;
         endcase
      end
      // mostly a position that exists, sometimes zero or out of range
      if (list_len > 0 && $urandom_range(99) < 80)
         c.position = POS_WIDTH'($urandom_range(list_len, 1));
      else if ($urandom_range(1) == 0)
         c.position = '0;
      return c;
   endfunction

   // offer one beat, wait for acceptance, record the expected reply
   task automatic offer_beat(input list_cmd_type c, input bit typed,
                             input list_reply_type typed_reply);
      list_reply_type r;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= c.cmd;
      req_ch.value    <= c.value;
      req_ch.position <= c.position;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      r = apply_command(c);
      expected_replies.push_back(typed ? typed_reply : r);
   endtask

   task automatic log_failure(input string msg);
      if (fail_count < 10)
         $display("%s", msg);
      fail_count++;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_wanted) begin
            long_hold_wanted = 1'b0;
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // compare every accepted reply beat against the oldest expectation
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_replies.size() == 0) begin
            log_failure($sformatf("unexpected reply beat: status %0d count %0d removed %0d",
                                  rsp_ch.status, rsp_ch.entry_count, rsp_ch.removed_value));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.entry_count !== want.entry_count ||
                rsp_ch.removed_value !== want.removed_value)
               log_failure($sformatf(
                  "reply mismatch: expected status %0d count %0d removed %0d, got %0d %0d %0d",
                  want.status, want.entry_count, want.removed_value,
                  rsp_ch.status, rsp_ch.entry_count, rsp_ch.removed_value));
         end
      end
   end

   // stimulus
   initial begin
      list_reply_type none;
      int unsigned append_pct;
      none.status        = ST_OK;
      none.entry_count   = '0;
      none.removed_value = '0;
      append_pct         = 50;
      fail_count         = 0;
      list_len           = 0;
      long_hold_wanted   = 1'b0;
      sender_idle_pct    = 9;
      receiver_idle_pct  = 72;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_APPEND;
      req_ch.value    <= '0;
      req_ch.position <= '0;

      // deletes on the empty list, whatever the position
      add_row(CMD_DEL_FIRST, 32'sd0, 5'd0, 1'b1, ST_EMPTY, 5'd0, 32'sd0);
      add_row(CMD_DEL_LAST, 32'sd0, 5'd0, 1'b1, ST_EMPTY, 5'd0, 32'sd0);
      add_row(CMD_DEL_AT_POS, 32'sd0, 5'd31, 1'b1, ST_EMPTY, 5'd0, 32'sd0);
      // value extremes, position zero, position one takes the head
      add_row(CMD_APPEND, 32'sh7fff_ffff, 5'd31, 1'b1, ST_OK, 5'd1, 32'sd0);
      add_row(CMD_APPEND, 32'sh8000_0000, 5'd0, 1'b1, ST_OK, 5'd2, 32'sd0);
      add_row(CMD_DEL_AT_POS, 32'sd0, 5'd0, 1'b1, ST_BADPOS, 5'd2, 32'sd0);
      add_row(CMD_DEL_AT_POS, 32'sd0, 5'd1, 1'b1, ST_OK, 5'd1, 32'sh7fff_ffff);
      add_row(CMD_DEL_LAST, 32'sd0, 5'd0, 1'b1, ST_OK, 5'd0, 32'sh8000_0000);
      // fill to the top, then append when full
      for (int k = 1; k <= LIST_DEPTH; k++)
         add_row(CMD_APPEND, (k == 1) ? -32'sd1 : 32'(k) * 32'h1357_9bdf, 5'd0,
                 1'b1, ST_OK, 5'(k), 32'sd0);
      add_row(CMD_APPEND, 32'sd5, 5'd0, 1'b1, ST_FULL, 5'd16, 32'sd0);
      // highest position, then one past the end, then a middle entry
      add_row(CMD_DEL_AT_POS, 32'sd0, 5'd16, 1'b0, ST_OK, 5'd0, 32'sd0);
      add_row(CMD_DEL_AT_POS, 32'sd0, 5'd16, 1'b1, ST_BADPOS, 5'd15, 32'sd0);
      add_row(CMD_DEL_AT_POS, 32'sd0, 5'd8, 1'b0, ST_OK, 5'd0, 32'sd0);
      add_row(CMD_DEL_FIRST, 32'sd0, 5'd0, 1'b0, ST_OK, 5'd0, 32'sd0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].reply);

      // random part in three idling phases, fill tendency changes every 40 beats
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 72;
            receiver_idle_pct = 9;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
            long_hold_wanted  = 1'b1;
         end
         if (n % 40 == 0) begin
            case ($urandom_range(2))
               0: append_pct = 25;
               1: append_pct = 50;
               default: append_pct = 80;
            endcase
         end
         offer_beat(random_command(append_pct), 1'b0, none);
      end
      req_ch.valid <= 1'b0;

      // drain, then a few cycles to catch stray beats
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/olad_pkg.sv
rtl/olad_ifs.sv
rtl/olad_cell.sv
rtl/ordered_list_append_delete_unit.sv
bench/testbench.sv
